@@ sv/lz4d_pkg.sv @@
package lz4d_pkg;

  localparam int HIST_AW = 16;           // history of 64 KiB
  localparam int LEN_W   = 23;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW   = 2;
  localparam int OQ_CW   = 3;

  localparam logic [LEN_W-1:0] LEN_MAX       = 23'h7FFFFF;
  localparam logic [LEN_W-1:0] MAX_BLOCK_RST = 23'd65536;

  localparam logic [3:0] NIBBLE_EXT = 4'd15;
  localparam logic [7:0] BYTE_EXT   = 8'd255;
  localparam logic [LEN_W-1:0] MATCH_MIN = 23'd4;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TRUNC     = 3'd1;
  localparam logic [2:0] ERR_CAPACITY  = 3'd2;
  localparam logic [2:0] ERR_OFFSET    = 3'd3;
  localparam logic [2:0] ERR_DATA_PEND = 3'd4;

  typedef struct packed {
    logic             has_byte;
    logic [7:0]       out_byte;
    logic             match_pending;
    logic             block_done;
    logic [LEN_W-1:0] block_length;
    logic [2:0]       error_code;
  } res_t;

  // request from the parser into the history stage
  typedef struct packed {
    logic               res_valid;
    logic               rd;
    logic [HIST_AW-1:0] raddr;
    logic               we;
    logic [HIST_AW-1:0] waddr;
    logic               from_mem;
    res_t               res;
  } hist_req_t;

endpackage

@@ sv/lz4_block_decompressor_core.sv @@
// Channel  Dir  Signals                         Payload
// in       in   in_tvalid/in_tready/in_tdata    data_byte; tuser op, block_compressed;
//                                              tlast block_last
// out      out  out_tvalid/out_tready/out_tdata out_byte, match_pending, block_length,
//                                              error_code; tuser has_byte; tlast block_done
// cfg      in   cfg_wr_en/cfg_wr_data           max_block_bytes
//
// One request is taken per cycle while in_tready is high; each is one parse step or one history read-write.
// A pull reads the 64 KiB history at acceptance and writes the byte back at the next edge;
// every result enters the output queue at that same edge, from the history stage's register.
// Reset is synchronous; the history is not cleared and needs no clearing pass.
// in_tready drops only when the four-entry result queue could overflow.
module lz4_block_decompressor_core
  import lz4d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic [1:0]       in_tuser,   // [0] op, [1] block_compressed
  input  logic             in_tlast,   // block_last
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata,  // [7:0] out_byte, [8] match_pending,
                                       // [31:9] block_length, [34:32] error_code
  output logic             out_tuser,  // has_byte
  output logic             out_tlast   // block_done
);

  hist_req_t        req;
  logic             acc;
  logic             p1_valid;
  res_t             p1_res;
  res_t             q_res;
  logic [OQ_CW-1:0] q_count;

  // hold off while the result in flight could not find a queue slot
  assign in_tready = ({1'b0, q_count} + {{OQ_CW{1'b0}}, p1_valid}) < (OQ_CW+1)'(OQ_DEPTH);
  assign acc = in_tvalid && in_tready;

  lz4d_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .op          (in_tuser[0]),
    .data_byte   (in_tdata),
    .comp        (in_tuser[1]),
    .last        (in_tlast),
    .req         (req)
  );

  lz4d_hist u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .res_valid (p1_valid),
    .res       (p1_res)
  );

  lz4d_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (p1_valid),
    .push_res (p1_res),
    .pop      (out_tready),
    .q_valid  (out_tvalid),
    .q_res    (q_res),
    .q_count  (q_count)
  );

  assign out_tdata = {5'd0, q_res.error_code, q_res.block_length,
                      q_res.match_pending, q_res.out_byte};
  assign out_tuser = q_res.has_byte;
  assign out_tlast = q_res.block_done;

endmodule

@@ sv/lz4d_parser.sv @@
module lz4d_parser
  import lz4d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  logic             acc,
  input  logic             op,
  input  logic [7:0]       data_byte,
  input  logic             comp,
  input  logic             last,
  output hist_req_t        req
);

  typedef enum logic [2:0] {
    PH_TOKEN, PH_EXT, PH_LIT, PH_OFF_LO, PH_OFF_HI, PH_MATCH, PH_ERROR, PH_STORED
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] out_count_r, out_count_nxt;
  logic [3:0]       nibble_r, nibble_nxt;
  logic [LEN_W-1:0] lit_left_r, lit_left_nxt;
  logic [LEN_W-1:0] match_left_r, match_left_nxt;
  logic [15:0]      offset_r, offset_nxt;
  logic [LEN_W-1:0] max_r, max_nxt;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
  endfunction

  function automatic logic over_cap(input logic [LEN_W-1:0] len,
                                    input logic [LEN_W-1:0] cnt,
                                    input logic [LEN_W-1:0] mx);
    logic [LEN_W:0] s;
    s = {1'b0, cnt} + {1'b0, len};
    return (len == LEN_MAX) || (s > {1'b0, mx});
  endfunction

  logic             fail_v;
  logic [2:0]       fail_code;
  logic             end_v;
  logic [LEN_W-1:0] cnt_inc;
  logic [LEN_W-1:0] s1, s2, dec;
  logic [15:0]      off;
  logic [LEN_W-1:0] b_ext;

  always_comb begin
    phase_nxt      = phase_r;
    out_count_nxt  = out_count_r;
    nibble_nxt     = nibble_r;
    lit_left_nxt   = lit_left_r;
    match_left_nxt = match_left_r;
    offset_nxt     = offset_r;
    max_nxt        = cfg_wr_en ? cfg_wr_data : max_r;
    req            = '0;
    req.raddr      = out_count_r[HIST_AW-1:0] - offset_r[HIST_AW-1:0];
    req.waddr      = out_count_r[HIST_AW-1:0];
    req.res.out_byte = data_byte;
    fail_v         = 1'b0;
    fail_code      = ERR_NONE;
    end_v          = 1'b0;
    cnt_inc        = out_count_r + LEN_W'(1);
    b_ext          = {{(LEN_W-8){1'b0}}, data_byte};
    s1             = '0;
    s2             = '0;
    dec            = '0;
    off            = {data_byte, offset_r[7:0]};

    if (acc) begin
      if (op == OP_PULL) begin
        if (phase_r == PH_MATCH) begin
          req.rd        = 1'b1;
          req.we        = 1'b1;
          req.from_mem  = 1'b1;
          req.res_valid = 1'b1;
          req.res.has_byte = 1'b1;
          out_count_nxt = cnt_inc;
          dec = match_left_r - LEN_W'(match_left_r != '0);
          match_left_nxt = dec;
          req.res.match_pending = (dec != '0);
          if (dec == '0) phase_nxt = PH_TOKEN;
        end
      end else begin
        unique case (phase_r) inside
          PH_ERROR: begin
            if (last) end_v = 1'b1;
          end
          PH_MATCH: begin
            fail_v = 1'b1;
            fail_code = ERR_DATA_PEND;
          end
          PH_STORED, PH_TOKEN: begin
            if (phase_r == PH_STORED || (out_count_r == '0 && !comp)) begin
              if (out_count_r >= max_r) begin
                fail_v = 1'b1;
                fail_code = ERR_CAPACITY;
              end else begin
                req.we = 1'b1;
                out_count_nxt = cnt_inc;
                req.res_valid = 1'b1;
                req.res.has_byte = 1'b1;
                if (last) begin
                  req.res.block_done = 1'b1;
                  req.res.block_length = cnt_inc;
                  end_v = 1'b1;
                end else begin
                  phase_nxt = PH_STORED;
                end
              end
            end else begin
              nibble_nxt = data_byte[3:0];
              if (data_byte[7:4] == NIBBLE_EXT) begin
                lit_left_nxt = LEN_W'(NIBBLE_EXT);
                phase_nxt = PH_EXT;
                if (last) begin
                  fail_v = 1'b1;
                  fail_code = ERR_TRUNC;
                end
              end else if (data_byte[7:4] != 4'd0) begin
                s1 = LEN_W'(data_byte[7:4]);
                lit_left_nxt = s1;
                if (over_cap(s1, out_count_r, max_r)) begin
                  fail_v = 1'b1;
                  fail_code = ERR_CAPACITY;
                end else if (last) begin
                  fail_v = 1'b1;
                  fail_code = ERR_TRUNC;
                end else begin
                  phase_nxt = PH_LIT;
                end
              end else if (last) begin
                req.res_valid = 1'b1;
                req.res.out_byte = '0;
                req.res.block_done = 1'b1;
                req.res.block_length = out_count_r;
                end_v = 1'b1;
              end else begin
                phase_nxt = PH_OFF_LO;
              end
            end
          end
          PH_EXT: begin
            if (lit_left_r != '0) begin
              s1 = sat_add(lit_left_r, b_ext);
              lit_left_nxt = s1;
              if (data_byte != BYTE_EXT) begin
                if (over_cap(s1, out_count_r, max_r)) begin
                  fail_v = 1'b1;
                  fail_code = ERR_CAPACITY;
                end else if (last) begin
                  fail_v = 1'b1;
                  fail_code = ERR_TRUNC;
                end else begin
                  phase_nxt = PH_LIT;
                end
              end else if (last) begin
                fail_v = 1'b1;
                fail_code = ERR_TRUNC;
              end
            end else begin
              s1 = sat_add(match_left_r, b_ext);
              match_left_nxt = s1;
              if (data_byte != BYTE_EXT) begin
                s2 = sat_add(s1, MATCH_MIN);
                match_left_nxt = s2;
                if (over_cap(s2, out_count_r, max_r)) begin
                  fail_v = 1'b1;
                  fail_code = ERR_CAPACITY;
                end else if (last) begin
                  fail_v = 1'b1;
                  fail_code = ERR_TRUNC;
                end else begin
                  phase_nxt = PH_MATCH;
                  req.res_valid = 1'b1;
                  req.res.out_byte = '0;
                  req.res.match_pending = 1'b1;
                end
              end else if (last) begin
                fail_v = 1'b1;
                fail_code = ERR_TRUNC;
              end
            end
          end
          PH_LIT: begin
            req.we = 1'b1;
            out_count_nxt = cnt_inc;
            dec = lit_left_r - LEN_W'(lit_left_r != '0);
            lit_left_nxt = dec;
            req.res_valid = 1'b1;
            req.res.has_byte = 1'b1;
            if (dec == '0) begin
              if (last) begin
                req.res.block_done = 1'b1;
                req.res.block_length = cnt_inc;
                end_v = 1'b1;
              end else begin
                phase_nxt = PH_OFF_LO;
              end
            end else if (last) begin
              fail_v = 1'b1;
              fail_code = ERR_TRUNC;
            end
          end
          PH_OFF_LO: begin
            offset_nxt = {8'd0, data_byte};
            phase_nxt = PH_OFF_HI;
            if (last) begin
              fail_v = 1'b1;
              fail_code = ERR_TRUNC;
            end
          end
          PH_OFF_HI: begin
            offset_nxt = off;
            if (off == '0 || {7'd0, off} > out_count_r) begin
              fail_v = 1'b1;
              fail_code = ERR_OFFSET;
            end else if (nibble_r == NIBBLE_EXT) begin
              match_left_nxt = LEN_W'(NIBBLE_EXT);
              phase_nxt = PH_EXT;
              if (last) begin
                fail_v = 1'b1;
                fail_code = ERR_TRUNC;
              end
            end else begin
              s2 = LEN_W'(nibble_r) + MATCH_MIN;
              match_left_nxt = s2;
              if (over_cap(s2, out_count_r, max_r)) begin
                fail_v = 1'b1;
                fail_code = ERR_CAPACITY;
              end else if (last) begin
                fail_v = 1'b1;
                fail_code = ERR_TRUNC;
              end else begin
                phase_nxt = PH_MATCH;
                req.res_valid = 1'b1;
                req.res.out_byte = '0;
                req.res.match_pending = 1'b1;
              end
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end

      // an error replaces whatever result the step had built
      if (fail_v) begin
        req.res_valid = 1'b1;
        req.res = '0;
        req.res.error_code = fail_code;
        if (last) end_v = 1'b1;
        else phase_nxt = PH_ERROR;
      end
      if (end_v) begin
        phase_nxt      = PH_TOKEN;
        out_count_nxt  = '0;
        lit_left_nxt   = '0;
        match_left_nxt = '0;
        offset_nxt     = '0;
        nibble_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TOKEN;
      out_count_r  <= '0;
      nibble_r     <= '0;
      lit_left_r   <= '0;
      match_left_r <= '0;
      offset_r     <= '0;
      max_r        <= MAX_BLOCK_RST;
    end else begin
      phase_r      <= phase_nxt;
      out_count_r  <= out_count_nxt;
      nibble_r     <= nibble_nxt;
      lit_left_r   <= lit_left_nxt;
      match_left_r <= match_left_nxt;
      offset_r     <= offset_nxt;
      max_r        <= max_nxt;
    end
  end

`ifndef SYNTH
  a_match_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_MATCH |-> (match_left_r != '0) && (offset_r != '0))
    else $error("match pending with zero length or offset");

  a_pull_once: assert property (@(posedge clk) disable iff (!rst_n)
    req.rd |-> req.we && req.from_mem && req.res_valid)
    else $error("history read without write-back");
`endif

endmodule

@@ sv/lz4d_hist.sv @@
module lz4d_hist
  import lz4d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  hist_req_t req,
  output logic      res_valid,
  output res_t      res
);

  logic [7:0] mem [2**HIST_AW];

  logic               p1_valid_r;
  logic               p1_we_r;
  logic               p1_from_mem_r;
  logic [HIST_AW-1:0] p1_waddr_r;
  res_t               p1_res_r;
  logic [7:0]         rd_data_r;
  logic               fwd_hit_r, fwd_hit_nxt;
  logic [7:0]         fwd_data_r;
  logic [7:0]         wdata;

  // a read that hits the entry being written this cycle takes the write data
  assign wdata = !p1_from_mem_r ? p1_res_r.out_byte :
                 (fwd_hit_r ? fwd_data_r : rd_data_r);
  assign fwd_hit_nxt = req.rd && p1_we_r && (p1_waddr_r == req.raddr);

  always_ff @(posedge clk) begin
    if (req.rd) rd_data_r <= mem[req.raddr];
    if (p1_we_r) mem[p1_waddr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p1_we_r    <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      p1_valid_r <= req.res_valid;
      p1_we_r    <= req.we;
      fwd_hit_r  <= fwd_hit_nxt;
    end
    p1_from_mem_r <= req.from_mem;
    p1_waddr_r    <= req.waddr;
    p1_res_r      <= req.res;
    fwd_data_r    <= wdata;
  end

  always_comb begin
    res = p1_res_r;
    res.out_byte = p1_from_mem_r ? wdata : p1_res_r.out_byte;
  end
  assign res_valid = p1_valid_r;

`ifndef SYNTH
  a_fwd_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> p1_from_mem_r && p1_we_r)
    else $error("forward hit without a pending history read");
`endif

endmodule

@@ sv/lz4d_outq.sv @@
module lz4d_outq
  import lz4d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  res_t             push_res,
  input  logic             pop,
  output logic             q_valid,
  output res_t             q_res,
  output logic [OQ_CW-1:0] q_count
);

  res_t             ent_r [OQ_DEPTH];
  logic [OQ_AW-1:0] head_r, tail_r;
  logic [OQ_CW-1:0] count_r, count_nxt;
  logic             do_pop;

  assign q_valid = (count_r != '0);
  assign q_res   = ent_r[head_r];
  assign q_count = count_r;
  assign do_pop  = pop && q_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) count_nxt = count_r + OQ_CW'(1);
    if (!push && do_pop) count_nxt = count_r - OQ_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) tail_r <= tail_r + OQ_AW'(1);
      if (do_pop) head_r <= head_r + OQ_AW'(1);
      count_r <= count_nxt;
    end
    if (push) ent_r[tail_r] <= push_res;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != OQ_CW'(OQ_DEPTH)) || do_pop)
    else $error("result queue overflow");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

import lz4d_pkg::*;

class lz4_scoreboard;
  typedef enum logic [2:0] {
    PS_TOKEN, PS_LEN_EXT, PS_LITERALS, PS_OFS_LO, PS_OFS_HI, PS_COPY, PS_DISCARD, PS_RAW
  } parse_t;

  bit [7:0]    hist [65536];
  int unsigned capacity;
  int unsigned produced;
  int unsigned lit_left;
  int unsigned copy_left;
  int unsigned distance;
  int unsigned nibble;
  parse_t      ph;
  res_t        expected_q [$];
  int unsigned mismatches;

  function new();
    capacity   = MAX_BLOCK_RST;
    mismatches = 0;
    clear_block();
  endfunction

  function void clear_block();
    ph        = PS_TOKEN;
    produced  = 0;
    lit_left  = 0;
    copy_left = 0;
    distance  = 0;
    nibble    = 0;
  endfunction

  function void push(logic has, logic [7:0] d, logic pend, logic done,
                     logic [LEN_W-1:0] len, logic [2:0] err);
    res_t r;
    r.has_byte      = has;
    r.out_byte      = has ? d : 8'd0;
    r.match_pending = pend;
    r.block_done    = done;
    r.block_length  = len;
    r.error_code    = err;
    expected_q.insert(expected_q.size(), r);
  endfunction

  function void put(int unsigned v);
    hist[produced % 65536] = v[7:0];
    produced = (produced + 1) & LEN_MAX;
  endfunction

  function int unsigned sat(int unsigned a, int unsigned b);
    return (a + b > LEN_MAX) ? LEN_MAX : a + b;
  endfunction

  function bit over_cap(int unsigned len);
    return len >= LEN_MAX || produced + len > capacity;
  endfunction

  // an error on the last byte frees the decoder at once, else drop until block end
  function void fail(logic [2:0] code, logic last);
    if (last) clear_block();
    else ph = PS_DISCARD;
    push(1'b0, 8'd0, 1'b0, 1'b0, '0, code);
  endfunction

  function void finish(logic has, logic [7:0] d);
    int unsigned len;
    len = produced;
    clear_block();
    push(has, d, 1'b0, 1'b1, len[LEN_W-1:0], ERR_NONE);
  endfunction

  function void raw_byte(logic [7:0] d, logic last);
    if (produced >= capacity) begin
      fail(ERR_CAPACITY, last);
      return;
    end
    put(d);
    if (last) finish(1'b1, d);
    else begin
      ph = PS_RAW;
      push(1'b1, d, 1'b0, 1'b0, '0, ERR_NONE);
    end
  endfunction

  function void lits_ready(logic last);
    if (over_cap(lit_left)) fail(ERR_CAPACITY, last);
    else if (last) fail(ERR_TRUNC, last);
    else ph = PS_LITERALS;
  endfunction

  function void copy_ready(logic last);
    if (over_cap(copy_left)) fail(ERR_CAPACITY, last);
    else if (last) fail(ERR_TRUNC, last);
    else begin
      ph = PS_COPY;
      push(1'b0, 8'd0, 1'b1, 1'b0, '0, ERR_NONE);
    end
  endfunction

  function void note_request(logic op, logic [7:0] d, logic comp, logic last);
    int unsigned v;
    if (op == OP_PULL) begin
      // a pull with no match waiting is ignored
      if (ph != PS_COPY) return;
      v = hist[(produced - distance) % 65536];
      put(v);
      if (copy_left > 0) copy_left--;
      if (copy_left == 0) ph = PS_TOKEN;
      push(1'b1, v[7:0], copy_left != 0, 1'b0, '0, ERR_NONE);
      return;
    end
    case (ph)
      PS_DISCARD: if (last) clear_block();
      PS_COPY:    fail(ERR_DATA_PEND, last);
      PS_RAW:     raw_byte(d, last);
      PS_TOKEN: begin
        if (produced == 0 && !comp) raw_byte(d, last);
        else begin
          nibble = d[3:0];
          if (d[7:4] == NIBBLE_EXT) begin
            lit_left = 15;
            ph = PS_LEN_EXT;
            if (last) fail(ERR_TRUNC, last);
          end else if (d[7:4] != 0) begin
            lit_left = d[7:4];
            lits_ready(last);
          end else if (last) finish(1'b0, 8'd0);
          else ph = PS_OFS_LO;
        end
      end
      PS_LEN_EXT: begin
        if (lit_left != 0) begin
          lit_left = sat(lit_left, d);
          if (d != BYTE_EXT) lits_ready(last);
          else if (last) fail(ERR_TRUNC, last);
        end else begin
          copy_left = sat(copy_left, d);
          if (d != BYTE_EXT) begin
            copy_left = sat(copy_left, MATCH_MIN);
            copy_ready(last);
          end else if (last) fail(ERR_TRUNC, last);
        end
      end
      PS_LITERALS: begin
        put(d);
        if (lit_left > 0) lit_left--;
        if (lit_left == 0) begin
          if (last) finish(1'b1, d);
          else begin
            ph = PS_OFS_LO;
            push(1'b1, d, 1'b0, 1'b0, '0, ERR_NONE);
          end
        end else if (last) fail(ERR_TRUNC, last);
        else push(1'b1, d, 1'b0, 1'b0, '0, ERR_NONE);
      end
      PS_OFS_LO: begin
        distance = d;
        ph = PS_OFS_HI;
        if (last) fail(ERR_TRUNC, last);
      end
      default: begin
        distance = (distance & 32'hFF) | (32'(d) << 8);
        if (distance == 0 || distance > produced) fail(ERR_OFFSET, last);
        else if (nibble == NIBBLE_EXT) begin
          copy_left = 15;
          ph = PS_LEN_EXT;
          if (last) fail(ERR_TRUNC, last);
        end else begin
          copy_left = nibble + MATCH_MIN;
          copy_ready(last);
        end
      end
    endcase
  endfunction

  function string fmt(res_t r);
    return $sformatf("has=%0d byte=%02h pend=%0d done=%0d len=%0d err=%0d", r.has_byte,
                     r.out_byte, r.match_pending, r.block_done, r.block_length, r.error_code);
  endfunction

  function void report(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected %s / got %s", what, fmt(want), fmt(got));
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (expected_q.size() == 0) begin
      report("unexpected result", '0, got);
      return;
    end
    want = expected_q.pop_front();
    if (got.has_byte !== want.has_byte || got.out_byte !== want.out_byte ||
        got.match_pending !== want.match_pending || got.block_done !== want.block_done ||
        got.block_length !== want.block_length || got.error_code !== want.error_code)
      report("result mismatch", want, got);
  endfunction
endclass

module tb;
  import lz4d_pkg::*;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       comp;
    logic       last;
  } lz4_req_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = 8'd0;
  logic [1:0]       in_tuser = 2'd0;   // [0] op, [1] block_compressed
  logic             in_tlast = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [39:0]      out_tdata;         // [7:0] out_byte, [8] match_pending,
                                       // [31:9] block_length, [34:32] error_code
  logic             out_tuser;         // has_byte
  logic             out_tlast;         // block_done

  res_t          seen;
  lz4_req_t      blk [$];
  bit            idle_on = 1'b1;
  int            stall_left = 0;
  lz4_scoreboard sb = new;

  lz4_block_decompressor_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  assign seen = {out_tuser, out_tdata[7:0], out_tdata[8], out_tlast, out_tdata[31:9],
                 out_tdata[34:32]};

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tuser[0], in_tdata, in_tuser[1], in_tlast);
      if (out_tvalid && out_tready) sb.check_result(seen);
    end
  end

  // receiver stalls in random bursts while idle_on is set
  always @(posedge clk) begin
    if (!idle_on) out_tready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else out_tready <= 1'b1;
  end

  function automatic void push_item(logic op, logic [7:0] d, logic comp, logic last);
    lz4_req_t r;
    r.op   = op;
    r.data = d;
    r.comp = comp;
    r.last = last;
    blk.insert(blk.size(), r);
  endfunction

  // block_compressed only matters on a block's first byte, so scramble it elsewhere
  function automatic void push_data(logic [7:0] d);
    push_item(OP_DATA, d, 1'($urandom_range(0, 1)), 1'b0);
  endfunction

  function automatic void push_pulls(int n);
    repeat (n) push_item(OP_PULL, 8'($urandom), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
  endfunction

  function automatic void push_ext(int n);
    while (n >= 255) begin
      push_data(BYTE_EXT);
      n -= 255;
    end
    push_data(8'(n));
  endfunction

  function automatic int pick_len();
    case ($urandom_range(0, 9))
      7:       return 15;
      8:       return 270;
      9:       return $urandom_range(15, 600);
      default: return $urandom_range(0, 14);
    endcase
  endfunction

  function automatic void build_compressed();
    int produced;
    int lit;
    int ml;
    int ofs;
    produced = 0;
    repeat ($urandom_range(0, 4)) begin
      lit = pick_len();
      if (produced == 0 && lit == 0) lit = 1;
      ml = pick_len();
      push_data({4'(lit > 15 ? 15 : lit), 4'(ml > 15 ? 15 : ml)});
      if (lit >= 15) push_ext(lit - 15);
      repeat (lit) push_data(8'($urandom));
      produced += lit;
      ofs = $urandom_range(1, produced > 65535 ? 65535 : produced);
      push_data(8'(ofs));
      push_data(8'(ofs >> 8));
      if (ml >= 15) push_ext(ml - 15);
      push_pulls(ml + 4);
      produced += ml + 4;
    end
    // closing sequence carries literals only
    lit = pick_len();
    push_data({4'(lit > 15 ? 15 : lit), 4'($urandom)});
    if (lit >= 15) push_ext(lit - 15);
    repeat (lit) push_data(8'($urandom));
    blk[0].comp = 1'b1;
    blk[blk.size() - 1].last = 1'b1;
  endfunction

  function automatic void build_stored();
    repeat ($urandom_range(1, 40)) push_data(8'($urandom));
    blk[0].comp = 1'b0;
    blk[blk.size() - 1].last = 1'b1;
  endfunction

  function automatic void mangle();
    int k;
    lz4_req_t r;
    k = $urandom_range(0, blk.size() - 1);
    case ($urandom_range(0, 3))
      0: begin
        // cut the block short at a data byte
        while (blk[k].op == OP_PULL) k--;
        blk[k].last = 1'b1;
        while (blk.size() > k + 1) void'(blk.pop_back());
      end
      1: begin
        while (blk[k].op == OP_PULL) k--;
        blk[k].data = 8'($urandom);
      end
      2: begin
        for (int i = k; i < blk.size(); i++) begin
          if (blk[i].op == OP_PULL) begin
            blk.delete(i);
            break;
          end
        end
      end
      default: begin
        r = blk[k];
        r.op = OP_PULL;
        repeat ($urandom_range(1, 3)) blk.insert(k, r);
      end
    endcase
  endfunction

  task automatic send_item(lz4_req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r.data;
    in_tuser  <= {r.comp, r.op};
    in_tlast  <= r.last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_blk();
    foreach (blk[i]) send_item(blk[i]);
    blk.delete();
  endtask

  task automatic run_random(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 3) == 0) build_stored();
      else build_compressed();
      if ($urandom_range(0, 4) == 0) mangle();
      // drop a block that would run far past the target
      if (sent + blk.size() > n + 100) blk.delete();
      else begin
        sent += blk.size();
        send_blk();
      end
    end
  endtask

  // wait until every expected result is out, then give the pipeline time to empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(logic [LEN_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.capacity = v;
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stored block, then a stray pull
    push_item(OP_DATA, 8'h00, 1'b0, 1'b0);
    push_item(OP_DATA, 8'hFF, 1'b1, 1'b1);
    push_item(OP_PULL, 8'h5A, 1'b1, 1'b1);
    // two literals, match of five, then a zero-literal closing token
    push_item(OP_DATA, 8'h21, 1'b1, 1'b0);
    push_item(OP_DATA, 8'hAA, 1'b0, 1'b0);
    push_item(OP_DATA, 8'h55, 1'b0, 1'b0);
    push_item(OP_DATA, 8'h01, 1'b0, 1'b0);
    push_item(OP_DATA, 8'h00, 1'b0, 1'b0);
    push_pulls(5);
    push_item(OP_DATA, 8'h00, 1'b1, 1'b1);
    // zero offset on the last byte
    push_item(OP_DATA, 8'h10, 1'b1, 1'b0);
    push_item(OP_DATA, 8'h11, 1'b0, 1'b0);
    push_item(OP_DATA, 8'h00, 1'b0, 1'b0);
    push_item(OP_DATA, 8'h00, 1'b0, 1'b1);
    // data byte while a match is waiting
    push_item(OP_DATA, 8'h10, 1'b1, 1'b0);
    push_item(OP_DATA, 8'h77, 1'b0, 1'b0);
    push_item(OP_DATA, 8'h01, 1'b0, 1'b0);
    push_item(OP_DATA, 8'h00, 1'b0, 1'b0);
    push_item(OP_DATA, 8'h33, 1'b0, 1'b1);
    // block ends inside a literal length extension
    push_item(OP_DATA, 8'hF0, 1'b1, 1'b1);
    send_blk();

    run_random(500);

    set_capacity(23'd1);
    run_random(200);

    set_capacity(23'd4194304);
    run_random(400);

    set_capacity(23'($urandom_range(8, 64)));
    run_random(400);

    set_capacity(23'($urandom_range(1000, 70000)));
    run_random(200);
    idle_on = 1'b0;
    run_random(300);

    settle();
    if (sb.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule

@@ sim.f @@
sv/lz4d_pkg.sv
sv/lz4d_parser.sv
sv/lz4d_hist.sv
sv/lz4d_outq.sv
sv/lz4_block_decompressor_core.sv
sim/tb.sv
